// ===== rtl/gha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types, codes and constants of the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int NUM_SLOTS   = 256;
  localparam int NUM_CLASSES = 4;
  localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam int ADDR_W   = 64;
  localparam int GEN_W    = 32;
  localparam int CLS_W    = 2;
  localparam int BSIZE_W  = 13;

  localparam int CLASS_LSB = 56;
  localparam int SLOT_LSB  = 32;
  localparam int HSLOT_W   = 24;

  localparam logic [GEN_W-1:0] GEN_MAX   = 32'hFFFF_FFFF;
  localparam logic [GEN_W-1:0] GEN_FIRST = 32'd1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_PARAM  = 2'd1,
    ST_NO_RES     = 2'd2,
    ST_BAD_HANDLE = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [CLS_W-1:0]  cls;
    logic [GEN_W-1:0]  generation;
  } slot_entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    slot_entry_t       data;
  } slot_wr_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
  } search_t;

  function automatic logic [BSIZE_W-1:0] class_size(input logic [CLS_W-1:0] cls);
    logic [BSIZE_W-1:0] sz;
    case (cls)
      2'd0:    sz = 13'd64;
      2'd1:    sz = 13'd256;
      2'd2:    sz = 13'd1024;
      default: sz = 13'd4096;
    endcase
    return sz;
  endfunction

endpackage

// ===== rtl/gha_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_if
// Request and response channels of the handle allocator (valid/ready).
// ----------------------------------------------------------------------------
interface gha_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  block_class;
  logic [63:0] block_address;
  logic [63:0] handle_in;
  logic [31:0] block_size;

  modport source (output valid, cmd, block_class, block_address, handle_in, block_size,
                  input ready);
  modport sink   (input valid, cmd, block_class, block_address, handle_in, block_size,
                  output ready);
endinterface

interface gha_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] handle_out;
  logic [12:0] block_size_out;
  logic        release_valid;
  logic [63:0] release_address;
  logic [1:0]  release_class;

  modport source (output valid, status, handle_out, block_size_out, release_valid,
                  release_address, release_class, input ready);
  modport sink   (input valid, status, handle_out, block_size_out, release_valid,
                  release_address, release_class, output ready);
endinterface

// ===== rtl/gha_slot_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_slot_mem
// Slot table: address, class and generation per slot in one synchronous RAM.
// ----------------------------------------------------------------------------
module gha_slot_mem (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               rd_en,
  input  logic [gha_pkg::SLOT_W-1:0]         rd_addr,
  output gha_pkg::slot_entry_t               rd_data,
  input  gha_pkg::slot_wr_t                  wr
);

  gha_pkg::slot_entry_t mem [gha_pkg::NUM_SLOTS];
  logic [gha_pkg::NUM_SLOTS-1:0] written;
  gha_pkg::slot_entry_t          rd_raw;
  logic                          rd_written;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // A slot never written holds its reset contents: generation one.
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_addr];
      end
    end
  end

  always_comb begin
    rd_data = rd_raw;
    if (!rd_written) begin
      rd_data.address    = '0;
      rd_data.cls        = '0;
      rd_data.generation = gha_pkg::GEN_FIRST;
    end
  end

endmodule

// ===== rtl/generational_handle_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit
// Generational handle table: allocate and free 64-bit handles with checks.
// ----------------------------------------------------------------------------
// A request is accepted in S_IDLE and finished in S_EXEC. In the accept
// cycle the free-slot search (a rotating priority encoder over the in-use
// bitmap, starting at the next pointer) or the handle's slot field picks a
// table entry and the slot RAM read is issued; in S_EXEC the read data is
// checked, the entry is written back and the result goes to the output
// register. The next request is accepted as soon as the result is in the
// output register, even if it has not been taken yet; the block stalls in
// S_EXEC only while the output register still holds an untaken item. The
// in-use bitmap and the RAM's written flags are flip-flops cleared by
// reset, so no clearing pass is needed after reset.
// Handles are class in bits 63..56, slot in bits 55..32, generation in 31..0.
// ----------------------------------------------------------------------------
module generational_handle_allocator_unit (
  input  logic      clk,
  input  logic      rst,
  gha_req_if.sink   req,
  gha_rsp_if.source rsp
);

  gha_pkg::state_t state, state_next;

  // In-use bitmap and round-robin pointer.
  logic [gha_pkg::NUM_SLOTS-1:0] in_use;
  logic [gha_pkg::SLOT_W-1:0]    next_slot;

  // Request held across the table read.
  logic                          r_cmd;
  logic [7:0]                    r_class;
  logic [63:0]                   r_addr;
  logic [63:0]                   r_handle;
  logic [31:0]                   r_size;
  logic                          r_found;
  logic [gha_pkg::SLOT_W-1:0]    r_slot;

  logic                          accept;
  logic                          exec_fire;
  gha_pkg::search_t              search;
  logic [gha_pkg::NUM_SLOTS-1:0] free_vec;
  logic [gha_pkg::NUM_SLOTS-1:0] free_hi;
  logic [gha_pkg::SLOT_W-1:0]    rd_addr;
  gha_pkg::slot_entry_t          entry;
  gha_pkg::slot_wr_t             wr;

  // Result computed in S_EXEC.
  gha_pkg::status_t              res_status;
  logic [63:0]                   res_handle;
  logic [12:0]                   res_bsize;
  logic                          res_rel;
  logic [63:0]                   res_rel_addr;
  logic [1:0]                    res_rel_class;
  logic                          set_use;
  logic                          clr_use;
  logic [gha_pkg::SLOT_W-1:0]    next_slot_next;

  function automatic gha_pkg::search_t first_set(
    input logic [gha_pkg::NUM_SLOTS-1:0] v
  );
    gha_pkg::search_t r;
    r = '0;
    for (int i = gha_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r.found = 1'b1;
        r.idx   = gha_pkg::SLOT_W'(i);
      end
    end
    return r;
  endfunction

  assign req.ready = (state == gha_pkg::S_IDLE);
  assign accept    = req.valid && req.ready;
  assign exec_fire = (state == gha_pkg::S_EXEC) && (!rsp.valid || rsp.ready);

  // Round-robin search: first free slot at or above the pointer, else wrap.
  always_comb begin
    free_vec = ~in_use;
    for (int i = 0; i < gha_pkg::NUM_SLOTS; i++) begin
      free_hi[i] = free_vec[i] && (gha_pkg::SLOT_W'(i) >= next_slot);
    end
    if (|free_hi) begin
      search = first_set(free_hi);
    end else begin
      search = first_set(free_vec);
    end
  end

  assign rd_addr = (req.cmd == gha_pkg::CMD_FREE) ?
                   req.handle_in[gha_pkg::SLOT_LSB +: gha_pkg::SLOT_W] : search.idx;

  gha_slot_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (entry),
    .wr      (wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gha_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      gha_pkg::S_IDLE: begin
        if (accept) begin
          state_next = gha_pkg::S_EXEC;
        end
      end
      gha_pkg::S_EXEC: begin
        if (exec_fire) begin
          state_next = gha_pkg::S_IDLE;
        end
      end
      default: state_next = gha_pkg::S_IDLE;
    endcase
  end

  // Hold the request while the table read is in flight.
  always_ff @(posedge clk) begin
    if (accept) begin
      r_cmd    <= req.cmd;
      r_class  <= req.block_class;
      r_addr   <= req.block_address;
      r_handle <= req.handle_in;
      r_size   <= req.block_size;
      r_found  <= search.found;
      r_slot   <= rd_addr;
    end
  end

  // Check the entry and build the result and the write-back.
  always_comb begin
    logic [7:0]                  h_class;
    logic [gha_pkg::HSLOT_W-1:0] h_slot;
    logic [31:0]                 h_gen;
    logic [gha_pkg::GEN_W-1:0]   gen_next;

    h_class  = r_handle[gha_pkg::CLASS_LSB +: 8];
    h_slot   = r_handle[gha_pkg::SLOT_LSB +: gha_pkg::HSLOT_W];
    h_gen    = r_handle[31:0];
    gen_next = (entry.generation == gha_pkg::GEN_MAX) ? gha_pkg::GEN_FIRST
               : entry.generation + gha_pkg::GEN_W'(1);

    res_status     = gha_pkg::ST_OK;
    res_handle     = '0;
    res_bsize      = '0;
    res_rel        = 1'b0;
    res_rel_addr   = '0;
    res_rel_class  = '0;
    set_use        = 1'b0;
    clr_use        = 1'b0;
    next_slot_next = next_slot;
    wr             = '0;
    wr.addr        = r_slot;

    if (r_cmd == gha_pkg::CMD_ALLOC) begin
      if (r_class >= 8'(gha_pkg::NUM_CLASSES)) begin
        res_status = gha_pkg::ST_BAD_PARAM;
      end else if (r_addr == '0) begin
        res_status = gha_pkg::ST_NO_RES;
      end else if (!r_found) begin
        // Table full: hand the pool block straight back.
        res_status    = gha_pkg::ST_NO_RES;
        res_rel       = 1'b1;
        res_rel_addr  = r_addr;
        res_rel_class = r_class[1:0];
      end else begin
        res_handle = {r_class, gha_pkg::HSLOT_W'(r_slot), entry.generation};
        res_bsize  = gha_pkg::class_size(r_class[1:0]);
        set_use    = 1'b1;
        wr.en      = 1'b1;
        wr.data.address    = r_addr;
        wr.data.cls        = r_class[1:0];
        wr.data.generation = entry.generation;
        if (r_slot == gha_pkg::SLOT_W'(gha_pkg::NUM_SLOTS - 1)) begin
          next_slot_next = '0;
        end else begin
          next_slot_next = r_slot + gha_pkg::SLOT_W'(1);
        end
      end
    end else begin
      if (r_handle == '0) begin
        res_status = gha_pkg::ST_BAD_PARAM;
      end else if (h_class >= 8'(gha_pkg::NUM_CLASSES) ||
                   {1'b0, h_slot} >= 25'(gha_pkg::NUM_SLOTS)) begin
        res_status = gha_pkg::ST_BAD_HANDLE;
      end else if ({19'b0, gha_pkg::class_size(h_class[1:0])} != r_size) begin
        res_status = gha_pkg::ST_BAD_PARAM;
      end else if (!in_use[r_slot] || entry.generation != h_gen ||
                   {6'b0, entry.cls} != h_class || entry.address == '0) begin
        // Double or stale free.
        res_status = gha_pkg::ST_BAD_HANDLE;
      end else begin
        res_rel       = 1'b1;
        res_rel_addr  = entry.address;
        res_rel_class = h_class[1:0];
        clr_use       = 1'b1;
        wr.en         = 1'b1;
        wr.data.address    = '0;
        wr.data.cls        = entry.cls;
        wr.data.generation = gen_next;
      end
    end

    // Commit only when the result moves into the output register.
    if (!exec_fire) begin
      wr.en          = 1'b0;
      set_use        = 1'b0;
      clr_use        = 1'b0;
      next_slot_next = next_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use    <= '0;
      next_slot <= '0;
    end else begin
      next_slot <= next_slot_next;
      if (set_use) begin
        in_use[r_slot] <= 1'b1;
      end
      if (clr_use) begin
        in_use[r_slot] <= 1'b0;
      end
    end
  end

  // Output register: holds a finished item until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (exec_fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      rsp.status          <= res_status;
      rsp.handle_out      <= res_handle;
      rsp.block_size_out  <= res_bsize;
      rsp.release_valid   <= res_rel;
      rsp.release_address <= res_rel_addr;
      rsp.release_class   <= res_rel_class;
    end
  end

endmodule
